FILE: rtl/ptts_pkg.sv
// Package with shared types, constants and helpers of the partitioned task tick scheduler.
package ptts_pkg;

    localparam int MAX_TASKS      = 16;
    localparam int MAX_PARTITIONS = 8;
    localparam int TIME_BITS      = 16;
    localparam int IDX_BITS       = $clog2(MAX_TASKS);
    localparam int CNT_BITS       = $clog2(MAX_TASKS + 1);
    localparam int PART_BITS      = 3;

    typedef logic [TIME_BITS-1:0] time_val_t;
    typedef logic [IDX_BITS-1:0]  idx_t;
    typedef logic [CNT_BITS-1:0]  cnt_t;
    typedef logic [PART_BITS-1:0] part_t;
    typedef logic [MAX_TASKS-1:0] mask_t;

    typedef enum logic [1:0] {
        ST_SUSPEND = 2'd0,
        ST_READY   = 2'd1,
        ST_RUNNING = 2'd2,
        ST_FINISH  = 2'd3
    } task_state_t;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_TICK = 2'd1,
        OP_READ = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        POL_RESPONSE = 2'd0,
        POL_RATE     = 2'd1,
        POL_DEADLINE = 2'd2,
        POL_SLACK    = 2'd3
    } policy_t;

    localparam logic CFG_POLICY = 1'b0;
    localparam logic CFG_COUNT  = 1'b1;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_STATUS,
        FSM_PEER,
        FSM_APPLY,
        FSM_FINISH,
        FSM_DONE
    } fsm_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic accept;
        logic do_load;
        logic do_read;
        logic tick_start;
        logic status_pre;
        logic peer_step;
        logic apply;
        logic finish_step;
        logic publish;
        idx_t task_i;
        idx_t peer_j;
    } ptts_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic need_peer;
        cnt_t count;
    } ptts_sts_t;

    function automatic time_val_t sat_inc(input time_val_t v);
        return (v == '1) ? v : v + time_val_t'(1);
    endfunction

endpackage

FILE: rtl/ptts_ctrl.sv
// Controller state machine that sequences loads, reads and the per-task tick walk.
module ptts_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          operation,
    input  logic [3:0]          task_index,
    output logic                out_valid,
    input  logic                out_ready,
    output ptts_pkg::ptts_cmd_t cmd,
    input  ptts_pkg::ptts_sts_t sts
);
    import ptts_pkg::*;

    fsm_t state_reg, state_next;
    idx_t i_reg, i_next;
    idx_t j_reg, j_next;
    logic ov_reg, ov_next;
    op_t  op;

    assign op = op_t'(operation);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FSM_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            ov_reg    <= ov_next;
        end
    end

    // The last task of the walk is count-1; a count of zero skips the walk.
    logic last_i, last_j;
    assign last_i = ({1'b0, i_reg} == (sts.count - cnt_t'(1)));
    assign last_j = ({1'b0, j_reg} == (sts.count - cnt_t'(1)));

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        ov_next    = ov_reg;
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        unique case (state_reg)
            FSM_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    i_next = '0;
                    j_next = '0;
                    if (op == OP_TICK && sts.count != '0)
                        state_next = FSM_STATUS;
                    else
                        state_next = FSM_DONE;
                end
            end
            FSM_STATUS:
            begin
                j_next = '0;
                state_next = sts.need_peer ? FSM_PEER : FSM_APPLY;
            end
            FSM_PEER:
            begin
                j_next = j_reg + idx_t'(1);
                if (last_j)
                    state_next = FSM_APPLY;
            end
            FSM_APPLY:
            begin
                i_next = i_reg + idx_t'(1);
                if (last_i)
                begin
                    i_next = '0;
                    state_next = FSM_FINISH;
                end
                else
                    state_next = FSM_STATUS;
            end
            FSM_FINISH:
            begin
                i_next = i_reg + idx_t'(1);
                if (last_i)
                    state_next = FSM_DONE;
            end
            FSM_DONE:
            begin
                ov_next = 1'b1;
                state_next = FSM_IDLE;
            end
            default: state_next = FSM_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready         = (state_reg == FSM_IDLE) && !ov_reg;
        out_valid        = ov_reg;
        cmd              = '0;
        cmd.task_i       = i_reg;
        cmd.peer_j       = j_reg;
        unique case (state_reg)
            FSM_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.accept     = 1'b1;
                    cmd.do_load    = (op == OP_LOAD);
                    cmd.do_read    = (op == OP_READ);
                    cmd.tick_start = (op == OP_TICK);
                    cmd.task_i     = idx_t'(task_index);
                end
            end
            FSM_STATUS: cmd.status_pre  = 1'b1;
            FSM_PEER:   cmd.peer_step   = 1'b1;
            FSM_APPLY:  cmd.apply       = 1'b1;
            FSM_FINISH: cmd.finish_step = 1'b1;
            FSM_DONE:   cmd.publish     = 1'b1;
            default:    cmd.publish     = 1'b0;
        endcase
    end
endmodule

FILE: rtl/ptts_dp.sv
// Datapath holding the task table, counters and the per-task update logic.
module ptts_dp (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic                      cfg_index,
    input  logic [4:0]                cfg_data,
    input  logic [3:0]                task_index,
    input  logic [15:0]               load_period,
    input  logic [15:0]               load_exec_time,
    input  logic [15:0]               load_deadline,
    input  logic [15:0]               load_release_offset,
    input  logic [2:0]                load_partition,
    input  logic [15:0]               current_time,
    input  logic [2:0]                active_partition,
    input  ptts_pkg::ptts_cmd_t       cmd,
    output ptts_pkg::ptts_sts_t       sts,
    output logic                      running_valid,
    output logic [3:0]                running_task,
    output logic                      partition_idle,
    output logic [15:0]               released_mask,
    output logic [15:0]               finished_mask,
    output logic [15:0]               worst_response_value
);
    import ptts_pkg::*;

    policy_t     policy_reg;
    cnt_t        count_reg;

    task_state_t st_reg   [MAX_TASKS];
    time_val_t   per_reg  [MAX_TASKS];
    time_val_t   exe_reg  [MAX_TASKS];
    time_val_t   ddl_reg  [MAX_TASKS];
    time_val_t   off_reg  [MAX_TASKS];
    part_t       prt_reg  [MAX_TASKS];
    time_val_t   rel_reg  [MAX_TASKS];
    time_val_t   ec_reg   [MAX_TASKS];
    time_val_t   rc_reg   [MAX_TASKS];
    time_val_t   wr_reg   [MAX_TASKS];

    time_val_t   now_reg;
    part_t       part_reg;
    mask_t       relm_reg, finm_reg;
    logic        idle_reg;
    // Pre-stage results for the current task.
    task_state_t pst_reg;
    time_val_t   prc_reg;
    logic        presp_reg;
    logic        better_reg;

    logic        rv_reg;
    idx_t        rt_reg;
    logic        pi_reg;
    mask_t       rm_reg, fm_reg;
    time_val_t   wv_reg;
    logic        tick_flag_reg;

    assign cfg_ready = 1'b1;

    idx_t i, j;
    assign i = cmd.task_i;
    assign j = cmd.peer_j;

    // Release stages of task i, evaluated from stored state.
    task_state_t s0;
    time_val_t   rc0;
    logic        resp0, rel0;
    always_comb
    begin
        s0    = st_reg[i];
        rc0   = rc_reg[i];
        resp0 = 1'b0;
        rel0  = 1'b0;
        if (s0 == ST_SUSPEND && now_reg >= off_reg[i])
        begin
            s0 = ST_READY; rel0 = 1'b1; resp0 = 1'b1; rc0 = sat_inc(rc0);
        end
        else if (s0 == ST_FINISH && now_reg >= rel_reg[i] &&
                 (now_reg - rel_reg[i]) >= per_reg[i])
        begin
            s0 = ST_READY; rel0 = 1'b1; resp0 = 1'b1; rc0 = sat_inc(rc0);
        end
    end

    // Peer compare of task j against task i, using i's updated count.
    logic in_peer;
    logic beats;
    logic signed [TIME_BITS:0] slk_i, slk_j;
    assign slk_i = $signed({1'b0, ddl_reg[i]}) - $signed({1'b0, exe_reg[i]});
    assign slk_j = $signed({1'b0, ddl_reg[j]}) - $signed({1'b0, exe_reg[j]});
    task_state_t stj;
    time_val_t   rcj;
    assign stj = (j == i) ? pst_reg : st_reg[j];
    assign rcj = (j == i) ? prc_reg : rc_reg[j];
    always_comb
    begin
        unique case (policy_reg)
            POL_RESPONSE: beats = rcj > prc_reg;
            POL_RATE:     beats = per_reg[j] < per_reg[i];
            POL_DEADLINE: beats = ddl_reg[j] < ddl_reg[i];
            POL_SLACK:    beats = slk_j < slk_i;
            default:      beats = 1'b0;
        endcase
        in_peer = (stj == ST_READY) && (prt_reg[j] == part_reg) && beats;
    end

    assign sts.need_peer = (s0 == ST_READY) || (s0 == ST_RUNNING);
    assign sts.count     = count_reg;

    // First running index for publish, over stored states.
    logic found;
    idx_t first_run;
    always_comb
    begin
        found = 1'b0;
        first_run = '0;
        for (int k = MAX_TASKS - 1; k >= 0; k--)
        begin
            if (cnt_t'(k) < count_reg && st_reg[k] == ST_RUNNING)
            begin
                found = 1'b1;
                first_run = idx_t'(k);
            end
        end
    end

    // Some active task runs: earlier tasks already updated by this tick,
    // later ones still as the previous tick left them.
    logic anyrun;
    always_comb
    begin
        anyrun = 1'b0;
        for (int k = 0; k < MAX_TASKS; k++)
        begin
            if (cnt_t'(k) < count_reg && st_reg[k] == ST_RUNNING)
                anyrun = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POL_RESPONSE;
            count_reg  <= '0;
            for (int k = 0; k < MAX_TASKS; k++)
            begin
                st_reg[k] <= ST_SUSPEND;
                rel_reg[k] <= '0;
                ec_reg[k]  <= '0;
                rc_reg[k]  <= '0;
                wr_reg[k]  <= '0;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == CFG_POLICY)
                    policy_reg <= policy_t'(cfg_data[1:0]);
                else
                    count_reg <= (cfg_data > 5'(MAX_TASKS)) ? cnt_t'(MAX_TASKS)
                                                          : cnt_t'(cfg_data);
            end
            if (cmd.do_load)
            begin
                st_reg[i]  <= ST_SUSPEND;
                rel_reg[i] <= '0;
                ec_reg[i]  <= '0;
                rc_reg[i]  <= '0;
                wr_reg[i]  <= '0;
            end
            if (cmd.apply)
            begin
                if (rel0)
                    rel_reg[i] <= now_reg;
                if (pst_reg == ST_READY)
                begin
                    rc_reg[i] <= presp_reg ? prc_reg : sat_inc(prc_reg);
                    if (!better_reg && !anyrun && prt_reg[i] == part_reg)
                    begin
                        // Starts running; the running stage then runs as well.
                        st_reg[i] <= (better_reg) ? ST_READY : ST_RUNNING;
                        ec_reg[i] <= sat_inc(ec_reg[i]);
                    end
                    else
                        st_reg[i] <= ST_READY;
                end
                else if (pst_reg == ST_RUNNING)
                begin
                    rc_reg[i] <= sat_inc(prc_reg);
                    ec_reg[i] <= sat_inc(ec_reg[i]);
                    st_reg[i] <= (better_reg || prt_reg[i] != part_reg)
                                 ? ST_READY : ST_RUNNING;
                end
                else
                    st_reg[i] <= pst_reg;
            end
            if (cmd.finish_step)
            begin
                if (st_reg[i] == ST_RUNNING && ec_reg[i] == exe_reg[i] &&
                    rc_reg[i] <= ddl_reg[i])
                begin
                    st_reg[i] <= ST_FINISH;
                    ec_reg[i] <= '0;
                    rc_reg[i] <= '0;
                    if (rc_reg[i] > wr_reg[i])
                        wr_reg[i] <= rc_reg[i];
                end
            end
        end
    end

    // Payload and walk scratch registers.
    always_ff @(posedge clk)
    begin
        if (cmd.do_load)
        begin
            per_reg[i] <= load_period;
            exe_reg[i] <= load_exec_time;
            ddl_reg[i] <= load_deadline;
            off_reg[i] <= load_release_offset;
            prt_reg[i] <= load_partition;
        end
        if (cmd.tick_start)
        begin
            now_reg  <= current_time;
            part_reg <= active_partition;
            relm_reg <= '0;
            finm_reg <= '0;
            idle_reg <= 1'b1;
        end
        if (cmd.status_pre)
        begin
            pst_reg    <= s0;
            prc_reg    <= rc0;
            presp_reg  <= resp0;
            better_reg <= 1'b0;
            if (rel0)
                relm_reg[i] <= 1'b1;
        end
        if (cmd.peer_step && in_peer)
            better_reg <= 1'b1;
        if (cmd.apply)
        begin
            // Final state of task i decides idle.
            if (prt_reg[i] == part_reg && pst_reg != ST_FINISH)
                idle_reg <= 1'b0;
        end
        if (cmd.finish_step && st_reg[i] == ST_RUNNING &&
            ec_reg[i] == exe_reg[i] && rc_reg[i] <= ddl_reg[i])
            finm_reg[i] <= 1'b1;
        if (cmd.do_read)
            wv_reg <= wr_reg[i];
        if (cmd.accept)
        begin
            rv_reg <= 1'b0;
            rt_reg <= '0;
            pi_reg <= 1'b0;
            rm_reg <= '0;
            fm_reg <= '0;
            if (!cmd.do_read)
                wv_reg <= '0;
        end
        if (cmd.publish && tick_flag_reg)
        begin
            rv_reg <= found;
            rt_reg <= first_run;
            pi_reg <= idle_reg;
            rm_reg <= relm_reg;
            fm_reg <= finm_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tick_flag_reg <= 1'b0;
        else if (cmd.accept)
            tick_flag_reg <= cmd.tick_start;
    end

    assign running_valid        = rv_reg;
    assign running_task         = 4'(rt_reg);
    assign partition_idle       = pi_reg;
    assign released_mask        = 16'(rm_reg);
    assign finished_mask        = 16'(fm_reg);
    assign worst_response_value = 16'(wv_reg);
endmodule

FILE: rtl/partitioned_task_tick_scheduler_unit.sv
// Top level of the partitioned task tick scheduler: controller plus datapath.
// A load, read or unknown item, and a tick with an active count of zero, goes
// straight from acceptance to the done state, which raises its result.
// A tick walks the first active_task_count entries: for each task a status
// step, a peer scan over all active_task_count entries through the shared
// compare unit when the task is Ready or Running, and an apply step; then a
// finish step per task and a publish step. The result sits in an output
// register; the next item is taken once it has been delivered. Configuration
// writes are always ready.
module partitioned_task_tick_scheduler_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [3:0]  task_index,
    input  logic [15:0] load_period,
    input  logic [15:0] load_exec_time,
    input  logic [15:0] load_deadline,
    input  logic [15:0] load_release_offset,
    input  logic [2:0]  load_partition,
    input  logic [15:0] current_time,
    input  logic [2:0]  active_partition,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [4:0]  cfg_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        running_valid,
    output logic [3:0]  running_task,
    output logic        partition_idle,
    output logic [15:0] released_mask,
    output logic [15:0] finished_mask,
    output logic [15:0] worst_response_value
);
    import ptts_pkg::*;

    ptts_cmd_t cmd;
    ptts_sts_t sts;

    ptts_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .operation(operation), .task_index(task_index),
        .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .sts(sts)
    );

    ptts_dp u_dp (
        .clk(clk), .rst_n(rst_n), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .task_index(task_index),
        .load_period(load_period), .load_exec_time(load_exec_time),
        .load_deadline(load_deadline), .load_release_offset(load_release_offset),
        .load_partition(load_partition), .current_time(current_time),
        .active_partition(active_partition), .cmd(cmd), .sts(sts),
        .running_valid(running_valid), .running_task(running_task),
        .partition_idle(partition_idle), .released_mask(released_mask),
        .finished_mask(finished_mask), .worst_response_value(worst_response_value)
    );
endmodule

FILE: verif/tb_partitioned_task_tick_scheduler_unit.sv
// Self-checking testbench for the partitioned task tick scheduler unit.
module tb_partitioned_task_tick_scheduler_unit;
    import ptts_pkg::*;

    // Watchdog limit in cycles without any accepted item, result or register write.
    localparam int STALL_LIMIT = 20000;
    // Quiet time after the last result before a register write or the end.
    localparam int SETTLE_CYCLES = 400;

    typedef struct {
        op_t           op;
        logic [3:0]    idx;
        logic [15:0]   period;
        logic [15:0]   exec_time;
        logic [15:0]   deadline;
        logic [15:0]   offset;
        logic [2:0]    part;
        logic [15:0]   now;
        logic [2:0]    act_part;
    } sched_item_t;

    typedef struct {
        logic        run_valid;
        logic [3:0]  run_task;
        logic        idle;
        logic [15:0] rel_mask;
        logic [15:0] fin_mask;
        logic [15:0] worst;
    } sched_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  operation;
    logic [3:0]  task_index;
    logic [15:0] load_period;
    logic [15:0] load_exec_time;
    logic [15:0] load_deadline;
    logic [15:0] load_release_offset;
    logic [2:0]  load_partition;
    logic [15:0] current_time;
    logic [2:0]  active_partition;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [4:0]  cfg_data;
    logic        out_valid;
    logic        out_ready;
    logic        running_valid;
    logic [3:0]  running_task;
    logic        partition_idle;
    logic [15:0] released_mask;
    logic [15:0] finished_mask;
    logic [15:0] worst_response_value;

    partitioned_task_tick_scheduler_unit DUT (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .operation           (operation),
        .task_index          (task_index),
        .load_period         (load_period),
        .load_exec_time      (load_exec_time),
        .load_deadline       (load_deadline),
        .load_release_offset (load_release_offset),
        .load_partition      (load_partition),
        .current_time        (current_time),
        .active_partition    (active_partition),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .running_valid       (running_valid),
        .running_task        (running_task),
        .partition_idle      (partition_idle),
        .released_mask       (released_mask),
        .finished_mask       (finished_mask),
        .worst_response_value(worst_response_value)
    );

    // Shadow copy of the scheduler: configuration and the per-task table.
    policy_t     sh_policy;
    logic [4:0]  sh_count;
    task_state_t sh_state   [MAX_TASKS];
    logic [15:0] sh_period  [MAX_TASKS];
    logic [15:0] sh_exec    [MAX_TASKS];
    logic [15:0] sh_dl      [MAX_TASKS];
    logic [15:0] sh_offset  [MAX_TASKS];
    logic [2:0]  sh_part    [MAX_TASKS];
    logic [15:0] sh_rel_t   [MAX_TASKS];
    logic [15:0] sh_exec_c  [MAX_TASKS];
    logic [15:0] sh_resp_c  [MAX_TASKS];
    logic [15:0] sh_worst   [MAX_TASKS];

    sched_item_t   pending_items[$];
    sched_result_t expected_results[$];
    sched_item_t   driven_item;

    int unsigned sender_idle_pct;
    int unsigned receiver_stall_pct;
    int unsigned mismatches;
    int unsigned quiet_cycles;
    logic [15:0] tick_clock;

    function automatic logic [15:0] bump(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    // True when some Ready task of the given partition beats task i.
    function automatic bit beaten_by_peer(input int i, input int n, input logic [2:0] p);
        bit hit;
        hit = 0;
        for (int j = 0; j < n; j++)
        begin
            if (sh_state[j] == ST_READY && sh_part[j] == p)
            begin
                case (sh_policy)
                    POL_RESPONSE: if (sh_resp_c[j] > sh_resp_c[i]) hit = 1;
                    POL_RATE:     if (sh_period[j] < sh_period[i]) hit = 1;
                    POL_DEADLINE: if (sh_dl[j] < sh_dl[i]) hit = 1;
                    default:
                        if ($signed({1'b0, sh_dl[j]}) - $signed({1'b0, sh_exec[j]}) <
                            $signed({1'b0, sh_dl[i]}) - $signed({1'b0, sh_exec[i]}))
                            hit = 1;
                endcase
            end
        end
        return hit;
    endfunction

    function automatic bit someone_running(input int n);
        for (int j = 0; j < n; j++)
            if (sh_state[j] == ST_RUNNING)
                return 1;
        return 0;
    endfunction

    // Computes the result of one accepted item and advances the shadow table.
    function automatic sched_result_t schedule_item(input sched_item_t it);
        sched_result_t r;
        int n;
        bit resp_done;
        r = '{default: '0};
        n = (sh_count > MAX_TASKS) ? MAX_TASKS : sh_count;
        case (it.op)
            OP_LOAD:
            begin
                sh_period[it.idx] = it.period;
                sh_exec[it.idx]   = it.exec_time;
                sh_dl[it.idx]     = it.deadline;
                sh_offset[it.idx] = it.offset;
                sh_part[it.idx]   = it.part;
                sh_state[it.idx]  = ST_SUSPEND;
                sh_rel_t[it.idx]  = '0;
                sh_exec_c[it.idx] = '0;
                sh_resp_c[it.idx] = '0;
                sh_worst[it.idx]  = '0;
            end
            OP_READ:
                r.worst = sh_worst[it.idx];
            OP_TICK:
            begin
                r.idle = 1'b1;
                for (int i = 0; i < n; i++)
                begin
                    resp_done = 0;
                    if (sh_state[i] == ST_SUSPEND && it.now >= sh_offset[i])
                    begin
                        sh_state[i] = ST_READY;
                        sh_rel_t[i] = it.now;
                        r.rel_mask[i] = 1'b1;
                        sh_resp_c[i] = bump(sh_resp_c[i]);
                        resp_done = 1;
                    end
                    if (sh_state[i] == ST_FINISH && it.now >= sh_rel_t[i] &&
                        it.now - sh_rel_t[i] >= sh_period[i])
                    begin
                        sh_state[i] = ST_READY;
                        sh_rel_t[i] = it.now;
                        r.rel_mask[i] = 1'b1;
                        if (!resp_done)
                        begin
                            sh_resp_c[i] = bump(sh_resp_c[i]);
                            resp_done = 1;
                        end
                    end
                    if (sh_state[i] == ST_READY)
                    begin
                        if (!beaten_by_peer(i, n, it.act_part) && !someone_running(n) &&
                            sh_part[i] == it.act_part)
                            sh_state[i] = ST_RUNNING;
                        if (!resp_done)
                        begin
                            sh_resp_c[i] = bump(sh_resp_c[i]);
                            resp_done = 1;
                        end
                    end
                    if (sh_state[i] == ST_RUNNING)
                    begin
                        if (beaten_by_peer(i, n, it.act_part) || sh_part[i] != it.act_part)
                            sh_state[i] = ST_READY;
                        if (!resp_done)
                            sh_resp_c[i] = bump(sh_resp_c[i]);
                        sh_exec_c[i] = bump(sh_exec_c[i]);
                    end
                end
                for (int i = 0; i < n; i++)
                    if (sh_part[i] == it.act_part && sh_state[i] != ST_FINISH)
                        r.idle = 1'b0;
                for (int i = 0; i < n; i++)
                begin
                    if (sh_state[i] == ST_RUNNING && sh_exec_c[i] == sh_exec[i] &&
                        sh_resp_c[i] <= sh_dl[i])
                    begin
                        sh_state[i] = ST_FINISH;
                        sh_exec_c[i] = '0;
                        if (sh_resp_c[i] > sh_worst[i])
                            sh_worst[i] = sh_resp_c[i];
                        sh_resp_c[i] = '0;
                        r.fin_mask[i] = 1'b1;
                    end
                end
                for (int i = n - 1; i >= 0; i--)
                begin
                    if (sh_state[i] == ST_RUNNING)
                    begin
                        r.run_valid = 1'b1;
                        r.run_task  = i[3:0];
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic sched_item_t blank_item(input op_t op);
        sched_item_t it;
        it.op        = op;
        it.idx       = 4'($urandom_range(0, 15));
        it.period    = 16'($urandom_range(0, 65535));
        it.exec_time = 16'($urandom_range(0, 65535));
        it.deadline  = 16'($urandom_range(0, 65535));
        it.offset    = 16'($urandom_range(0, 65535));
        it.part      = 3'($urandom_range(0, 7));
        it.now       = 16'($urandom_range(0, 65535));
        it.act_part  = 3'($urandom_range(0, 7));
        return it;
    endfunction

    // A load with small, schedulable timing so that tasks actually finish.
    function automatic sched_item_t sane_load(input logic [3:0] idx);
        sched_item_t it;
        it = blank_item(OP_LOAD);
        it.idx       = idx;
        it.period    = 16'($urandom_range(1, 24));
        it.exec_time = 16'($urandom_range(0, 4));
        it.deadline  = 16'($urandom_range(0, 40));
        it.offset    = 16'(tick_clock + $urandom_range(0, 20));
        it.part      = 3'($urandom_range(0, 3));
        return it;
    endfunction

    function automatic sched_item_t tick_at(input logic [15:0] t, input logic [2:0] p);
        sched_item_t it;
        it = blank_item(OP_TICK);
        it.now      = t;
        it.act_part = p;
        return it;
    endfunction

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Driver: presents queued items and predicts each one as it is accepted.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                expected_results.push_back(schedule_item(driven_item));
            if (!in_valid || in_ready)
            begin
                if (pending_items.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct)
                begin
                    driven_item = pending_items.pop_front();
                    in_valid            <= 1'b1;
                    operation           <= driven_item.op;
                    task_index          <= driven_item.idx;
                    load_period         <= driven_item.period;
                    load_exec_time      <= driven_item.exec_time;
                    load_deadline       <= driven_item.deadline;
                    load_release_offset <= driven_item.offset;
                    load_partition      <= driven_item.part;
                    current_time        <= driven_item.now;
                    active_partition    <= driven_item.act_part;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each delivered result against the oldest prediction.
    always @(posedge clk)
    begin
        sched_result_t want;
        if (rst_n)
        begin
            out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: nothing was predicted");
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (running_valid !== want.run_valid || running_task !== want.run_task ||
                        partition_idle !== want.idle || released_mask !== want.rel_mask ||
                        finished_mask !== want.fin_mask || worst_response_value !== want.worst)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp run %0b/%0d idle %0b rel %h fin %h worst %0d, got run %0b/%0d idle %0b rel %h fin %h worst %0d",
                                want.run_valid, want.run_task, want.idle, want.rel_mask,
                                want.fin_mask, want.worst, running_valid, running_task,
                                partition_idle, released_mask, finished_mask,
                                worst_response_value);
                    end
                end
            end
        end
    end

    // Watchdog: a long stretch with no accepted item, result or write ends the run.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Waits until every queued item has been taken and every result has come.
    task automatic drain();
        while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes one register while the block is idle and mirrors it in the shadow.
    task automatic write_reg(input logic idx, input logic [4:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_POLICY)
            sh_policy = policy_t'(value[1:0]);
        else
            sh_count = value;
    endtask

    initial
    begin
        int unsigned roll;
        logic [4:0] counts [8];
        sched_item_t it;
        counts = '{5'd16, 5'd0, 5'd1, 5'd31, 5'd5, 5'd16, 5'd2, 5'd10};

        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = '0;
        task_index = '0;
        load_period = '0;
        load_exec_time = '0;
        load_deadline = '0;
        load_release_offset = '0;
        load_partition = '0;
        current_time = '0;
        active_partition = '0;
        cfg_valid = 1'b0;
        cfg_index = 1'b0;
        cfg_data = '0;
        out_ready = 1'b0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        mismatches = 0;
        quiet_cycles = 0;
        tick_clock = '0;
        sh_policy = POL_RESPONSE;
        sh_count = '0;
        for (int i = 0; i < MAX_TASKS; i++)
        begin
            sh_state[i] = ST_SUSPEND;
            sh_period[i] = '0;
            sh_exec[i] = '0;
            sh_dl[i] = '0;
            sh_offset[i] = '0;
            sh_part[i] = '0;
            sh_rel_t[i] = '0;
            sh_exec_c[i] = '0;
            sh_resp_c[i] = '0;
            sh_worst[i] = '0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: every entry is loaded before any tick so that no
        // scheduled task is ever left unloaded. Field extremes sit on a few
        // entries; a zero period, zero execution time and zero deadline too.
        for (int i = 0; i < MAX_TASKS; i++)
            pending_items.push_back(sane_load(4'(i)));
        it = sane_load(4'd15);
        it.period = 16'hFFFF; it.exec_time = 16'hFFFF; it.deadline = 16'hFFFF;
        it.offset = 16'hFFFF; it.part = 3'd7;
        pending_items.push_back(it);
        it = sane_load(4'd0);
        it.period = '0; it.exec_time = '0; it.deadline = '0; it.offset = '0; it.part = '0;
        pending_items.push_back(it);
        drain();
        write_reg(CFG_COUNT, 5'd16);
        write_reg(CFG_POLICY, POL_RESPONSE);
        pending_items.push_back(tick_at(16'd0, 3'd0));
        pending_items.push_back(tick_at(16'd1, 3'd7));
        pending_items.push_back(tick_at(16'd2, 3'd1));
        pending_items.push_back(blank_item(OP_NONE));
        it = blank_item(OP_READ); it.idx = 4'd0; pending_items.push_back(it);
        pending_items.push_back(tick_at(16'hFFFF, 3'd7));
        it = blank_item(OP_READ); it.idx = 4'd15; pending_items.push_back(it);
        tick_clock = 16'd3;

        // Random phases: each one runs a policy, a task count and an idling mode.
        for (int ph = 0; ph < 8; ph++)
        begin
            drain();
            write_reg(CFG_POLICY, 5'(ph % 4));
            write_reg(CFG_COUNT, counts[ph]);
            case (ph % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 63; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 63; end
                default: begin sender_idle_pct = 28; receiver_stall_pct = 28; end
            endcase
            for (int k = 0; k < 150; k++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 8)
                    it = sane_load(4'($urandom_range(0, 15)));
                else if (roll < 10)
                    it = blank_item(OP_LOAD);
                else if (roll < 20)
                    it = blank_item(OP_READ);
                else if (roll < 22)
                    it = blank_item(OP_NONE);
                else if (roll < 25)
                    it = blank_item(OP_TICK);
                else
                begin
                    // Mostly steady time with small steps, now and then a jump.
                    tick_clock = tick_clock + 16'($urandom_range(0, 3));
                    if ($urandom_range(0, 99) < 3)
                        tick_clock = 16'($urandom_range(0, 65535));
                    it = tick_at(tick_clock, ($urandom_range(0, 9) == 0) ?
                                 3'($urandom_range(0, 7)) : 3'($urandom_range(0, 3)));
                end
                pending_items.push_back(it);
            end
        end

        drain();
        if (mismatches == 0 && expected_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: sim.f
rtl/ptts_pkg.sv
rtl/ptts_ctrl.sv
rtl/ptts_dp.sv
rtl/partitioned_task_tick_scheduler_unit.sv
verif/tb_partitioned_task_tick_scheduler_unit.sv
